// File: rtl/core/tcrc_pkg.sv
package tcrc_pkg;

  localparam int MAX_ITEMS_DEF = 1024;
  localparam int ITEM_W        = 11;
  localparam int COUNT_W       = 10;
  localparam int TOTAL_W       = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_W-1:0] ITEM_COUNT_RST = 10'd1023;

  // class hypothesis offsets, in multiples of MAX_ITEMS
  localparam logic [1:0] CLS_A = 2'd0;
  localparam logic [1:0] CLS_B = 2'd1;
  localparam logic [1:0] CLS_C = 2'd2;

  // two check pairs, then three join pairs
  typedef enum logic [2:0] {
    PAIR_CHK0  = 3'd0,
    PAIR_CHK1  = 3'd1,
    PAIR_JOIN0 = 3'd2,
    PAIR_JOIN1 = 3'd3,
    PAIR_JOIN2 = 3'd4
  } pair_t;

  typedef struct packed {
    logic  load;
    logic  mark_trivial;
    logic  set_bad;
    logic  start_find;
    logic  step;
    logic  save_ra;
    logic  write_join;
    logic  clear_write;
    logic  finish;
    pair_t pair;
    logic  side;
  } tcrc_cmd_t;

  typedef struct packed {
    logic trivial;
    logic at_root;
    logic roots_equal;
    logic clear_last;
    logic out_free;
  } tcrc_status_t;

  // class offset of one side of a pair; side 0 takes the first item
  function automatic logic [1:0] slot_offset(logic eats, pair_t pair, logic side);
    logic [1:0] k;
    k = CLS_A;
    unique case (pair)
      PAIR_CHK0:  k = (!eats && side) ? CLS_B : CLS_A;
      PAIR_CHK1:  k = side ? CLS_A : CLS_B;
      PAIR_JOIN0: k = (eats && side) ? CLS_B : CLS_A;
      PAIR_JOIN1: k = side ? (eats ? CLS_C : CLS_B) : CLS_B;
      PAIR_JOIN2: k = side ? (eats ? CLS_A : CLS_C) : CLS_C;
      default:    k = CLS_A;
    endcase
    return k;
  endfunction

  function automatic pair_t next_pair(pair_t pair);
    pair_t p;
    p = PAIR_CHK0;
    unique case (pair)
      PAIR_CHK0:  p = PAIR_CHK1;
      PAIR_CHK1:  p = PAIR_JOIN0;
      PAIR_JOIN0: p = PAIR_JOIN1;
      PAIR_JOIN1: p = PAIR_JOIN2;
      PAIR_JOIN2: p = PAIR_CHK0;
      default:    p = PAIR_CHK0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/core/three_class_relation_checker.sv
// Three-class relation checker.
// Input channel (in_valid/in_ready): one claim per request, func = 0 for
// "same class", 1 for "first_item eats second_item".
// Output channel (out_valid/out_ready): one result per claim, claim_false
// and the saturating running count false_count.
// Config: cfg_we writes cfg_data into item_count at once; write only while idle.
// Per claim: a claim out of range or with equal items goes straight from start
// to done. Otherwise each claim runs up to 10 root finds (two check pairs,
// three join pairs) on the one read port of the parent table, with a read and
// a compare per chain step.
// The next claim is taken as soon as a result is loaded into the output
// register, even if that result is still waiting.
// Reset: the parent table is initialised by a pass over all 3*MAX_ITEMS entries,
// one entry per cycle, each written to point to itself; in_ready stays low
// until the pass ends. The false count returns to zero and item_count to 1023.
// Receiver stall: one result is held in the output register; a finished claim
// waits in its last state until the register frees up.
module three_class_relation_checker import tcrc_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [ITEM_W-1:0]  first_item,
  input  logic [ITEM_W-1:0]  second_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               claim_false,
  output logic [TOTAL_W-1:0] false_count,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data
);

  tcrc_cmd_t    cmd;
  tcrc_status_t status;

  tcrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcrc_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .func        (func),
    .first_item  (first_item),
    .second_item (second_item),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .claim_false (claim_false),
    .false_count (false_count)
  );

endmodule

// File: rtl/core/tcrc_ram.sv
module tcrc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tcrc_datapath.sv
module tcrc_datapath import tcrc_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tcrc_cmd_t           cmd,
  output tcrc_status_t        status,
  input  logic                func,
  input  logic [ITEM_W-1:0]   first_item,
  input  logic [ITEM_W-1:0]   second_item,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                claim_false,
  output logic [TOTAL_W-1:0]  false_count
);

  localparam int SLOTS = 3 * MAX_ITEMS;
  localparam int SW    = $clog2(SLOTS);
  localparam logic [SW-1:0] N1   = SW'(MAX_ITEMS);
  localparam logic [SW-1:0] N2   = SW'(2 * MAX_ITEMS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  logic                eats;
  logic [ITEM_W-1:0]   x;
  logic [ITEM_W-1:0]   y;
  logic [SW-1:0]       cur;
  logic [SW-1:0]       ra;
  logic                bad;
  logic [SW-1:0]       clr_cnt;
  logic [COUNT_W-1:0]  item_count;
  logic [TOTAL_W-1:0]  false_total;

  logic [SW-1:0]       rdata;
  logic [SW-1:0]       slot;
  logic [SW-1:0]       base;
  logic [1:0]          k;
  logic                in_range;
  logic                ram_we;
  logic [SW-1:0]       ram_waddr;
  logic [SW-1:0]       ram_wdata;

  tcrc_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_parent (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur),
    .rdata (rdata)
  );

  always_comb begin
    base = cmd.side ? SW'(y) : SW'(x);
    k    = slot_offset(eats, cmd.pair, cmd.side);
    unique case (k)
      CLS_B:   slot = base + N1;
      CLS_C:   slot = base + N2;
      default: slot = base;
    endcase
  end

  assign in_range = ({1'b0, item_count} >= x) && ({1'b0, item_count} >= y) &&
                    (32'(x) < MAX_ITEMS) && (32'(y) < MAX_ITEMS);

  assign ram_we    = cmd.clear_write || cmd.write_join;
  assign ram_waddr = cmd.clear_write ? clr_cnt : ra;
  assign ram_wdata = cmd.clear_write ? clr_cnt : cur;

  assign status.trivial     = !in_range || (x == y);
  assign status.at_root     = (rdata == cur);
  assign status.roots_equal = (ra == cur);
  assign status.clear_last  = (clr_cnt == LAST);
  assign status.out_free    = !out_valid || out_ready;

  assign false_count = false_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      item_count  <= ITEM_COUNT_RST;
      false_total <= '0;
      out_valid   <= 1'b0;
      bad         <= 1'b0;
    end else begin
      if (cfg_we) begin
        item_count <= cfg_data;
      end
      if (cmd.clear_write) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.load) begin
        bad <= 1'b0;
      end else if (cmd.mark_trivial) begin
        bad <= !in_range || eats;
      end else if (cmd.set_bad) begin
        bad <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (bad && false_total != TOTAL_MAX) begin
          false_total <= false_total + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      eats <= func;
      x    <= first_item;
      y    <= second_item;
    end
    if (cmd.start_find) begin
      cur <= slot;
    end else if (cmd.step) begin
      cur <= rdata;
    end
    if (cmd.save_ra) begin
      ra <= cur;
    end
    if (cmd.finish) begin
      claim_false <= bad;
    end
  end

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not presented after finish");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> false_total >= $past(false_total))
    else $error("false total decreased");

endmodule

// File: rtl/core/tcrc_ctrl.sv
module tcrc_ctrl import tcrc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tcrc_status_t status,
  output tcrc_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_START = 6'b000100,
    ST_RD    = 6'b001000,
    ST_CMP   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  pair_t  pair, pair_next;
  logic   side, side_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    pair_next  = pair;
    side_next  = side;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (status.trivial) begin
          cmd.mark_trivial = 1'b1;
          state_next       = ST_DONE;
        end else begin
          pair_next      = PAIR_CHK0;
          side_next      = 1'b0;
          cmd.start_find = 1'b1;
          state_next     = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!status.at_root) begin
          cmd.step   = 1'b1;
          state_next = ST_RD;
        end else if (!side) begin
          cmd.save_ra    = 1'b1;
          side_next      = 1'b1;
          cmd.start_find = 1'b1;
          state_next     = ST_RD;
        end else if (pair == PAIR_CHK0 || pair == PAIR_CHK1) begin
          if (status.roots_equal) begin
            cmd.set_bad = 1'b1;
            state_next  = ST_DONE;
          end else begin
            pair_next      = next_pair(pair);
            side_next      = 1'b0;
            cmd.start_find = 1'b1;
            state_next     = ST_RD;
          end
        end else begin
          // root of second slot is in cur: link first root under it
          cmd.write_join = 1'b1;
          if (pair == PAIR_JOIN2) begin
            state_next = ST_DONE;
          end else begin
            pair_next      = next_pair(pair);
            side_next      = 1'b0;
            cmd.start_find = 1'b1;
            state_next     = ST_RD;
          end
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
    cmd.pair = pair_next;
    cmd.side = side_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pair  <= PAIR_CHK0;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      pair  <= pair_next;
      side  <= side_next;
    end
  end

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("request accepted during table clear");

  a_join_after_check: assert property (@(posedge clk) disable iff (rst)
    cmd.write_join |-> (pair == PAIR_JOIN0 || pair == PAIR_JOIN1 || pair == PAIR_JOIN2))
    else $error("table written during check phase");

  a_find_from_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start_find |=> (state == ST_RD))
    else $error("find started without a read");

endmodule
